// ===== hdl/kfd_pkg.sv =====
package kfd_pkg;

    // Sizes of the job store and the session table.
    localparam int QUEUE_DEPTH      = 16;
    localparam int SESSION_COUNT    = 256;
    localparam int ACTIVE_LIMIT_MAX = 16;

    localparam int QIDX_W = $clog2(QUEUE_DEPTH);
    localparam int SLOT_W = $clog2(SESSION_COUNT);

    // Fixed field widths of the item and the result.
    localparam int CMD_W      = 2;
    localparam int SESSION_W  = 8;
    localparam int DELIVERY_W = 16;
    localparam int STATUS_W   = 3;
    localparam int COUNT_W    = 5;
    localparam int DATA_W     = 32;
    localparam int ADDR_W     = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_SUBMIT    = 2'd0,
        CMD_TRY_BEGIN = 2'd1,
        CMD_END_TURN  = 2'd2,
        CMD_PUMP      = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_NO_EXEC     = 3'd1,
        ST_BUSY        = 3'd2,
        ST_CAPACITY    = 3'd3,
        ST_FULL        = 3'd4,
        ST_NONE        = 3'd5,
        ST_END_IGNORED = 3'd6
    } status_t;

    // Register indexes, decoded from the word address.
    typedef enum logic {
        REG_MAX_ACTIVE   = 1'b0,
        REG_ENGINE_READY = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        CS_IDLE = 2'd0,
        CS_EXEC = 2'd1,
        CS_SCAN = 2'd2,
        CS_HOLD = 2'd3
    } ctrl_state_t;

    typedef struct packed {
        logic [COUNT_W-1:0] max_active_turns;
        logic               engine_ready;
    } cfg_t;

    typedef struct packed {
        status_t               status;
        logic                  dispatched;
        logic [SESSION_W-1:0]  session;
        logic [DELIVERY_W-1:0] delivery;
        logic [COUNT_W-1:0]    pending;
        logic [COUNT_W-1:0]    active;
    } result_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic exec;
        logic scan_step;
        logic load_live;
        logic save_res;
        logic load_saved;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic quick;
        logic scan_done;
        logic clearing;
    } dp_stat_t;

endpackage

// ===== hdl/kfd_cfg.sv =====
module kfd_cfg (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [kfd_pkg::ADDR_W-1:0] paddr,
    input  logic [kfd_pkg::DATA_W-1:0] pwdata,
    output logic [kfd_pkg::DATA_W-1:0] prdata,
    output logic                      pready,
    output kfd_pkg::cfg_t             cfg
);
    import kfd_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t reg_sel;
    logic     wr_en;

    assign reg_sel = reg_idx_t'(paddr[2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_sel)
                REG_MAX_ACTIVE:   cfg_next.max_active_turns = pwdata[COUNT_W-1:0];
                REG_ENGINE_READY: cfg_next.engine_ready     = pwdata[0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_MAX_ACTIVE:   prdata = {{(DATA_W-COUNT_W){1'b0}}, cfg_reg.max_active_turns};
            REG_ENGINE_READY: prdata = {{(DATA_W-1){1'b0}}, cfg_reg.engine_ready};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_active_turns <= COUNT_W'(1);
            cfg_reg.engine_ready     <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== hdl/kfd_dp.sv =====
module kfd_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  kfd_pkg::cfg_t                 cfg,
    input  logic [kfd_pkg::CMD_W-1:0]     command,
    input  logic [kfd_pkg::SESSION_W-1:0] session_id,
    input  logic [kfd_pkg::DELIVERY_W-1:0] delivery_id,
    input  kfd_pkg::dp_cmd_t              cmd,
    output kfd_pkg::dp_stat_t             stat,
    output kfd_pkg::result_t              out_res
);
    import kfd_pkg::*;

    logic [SESSION_W-1:0]  q_sess_reg [QUEUE_DEPTH];
    logic [DELIVERY_W-1:0] q_dlv_reg  [QUEUE_DEPTH];
    logic                  busy_mem   [SESSION_COUNT];
    logic                  busy_rd_reg;
    logic                  clearing_reg;
    logic [SLOT_W-1:0]     clr_idx_reg;
    cmd_t                  op_reg;
    logic [SESSION_W-1:0]  sid_reg;
    logic [DELIVERY_W-1:0] dlv_reg;
    logic [COUNT_W-1:0]    fill_reg;
    logic [COUNT_W-1:0]    fill_next;
    logic [COUNT_W-1:0]    active_reg;
    logic [COUNT_W-1:0]    active_next;
    logic [QIDX_W-1:0]     scan_idx_reg;
    logic [QIDX_W-1:0]     scan_idx_next;
    result_t               out_res_reg;
    result_t               hold_res_reg;

    cmd_t                  op_in;
    logic [COUNT_W-1:0]    limit;
    logic [SESSION_W-1:0]  scan_sess;
    logic [DELIVERY_W-1:0] scan_dlv;
    logic                  scan_last;
    logic [QIDX_W-1:0]     step_idx;
    logic                  q_push;
    logic                  q_compact;
    logic                  busy_wr_en;
    logic [SLOT_W-1:0]     busy_wr_slot;
    logic                  busy_wr_val;
    logic                  rd_en;
    logic [SLOT_W-1:0]     rd_addr;
    logic                  mem_wr_en;
    logic [SLOT_W-1:0]     mem_wr_slot;
    logic                  mem_wr_val;
    result_t               res_live;

    assign op_in     = cmd_t'(command);
    assign scan_sess = q_sess_reg[scan_idx_reg];
    assign scan_dlv  = q_dlv_reg[scan_idx_reg];
    assign step_idx  = scan_idx_reg + QIDX_W'(1);
    assign scan_last = (COUNT_W'(scan_idx_reg) + COUNT_W'(1)) == fill_reg;

    // The clearing pass owns the session table's write port after reset.
    assign mem_wr_en   = clearing_reg || busy_wr_en;
    assign mem_wr_slot = clearing_reg ? clr_idx_reg : busy_wr_slot;
    assign mem_wr_val  = busy_wr_val && !clearing_reg;

    // A limit of zero acts as one; values above ACTIVE_LIMIT_MAX are clamped to it.
    always_comb
    begin
        if (cfg.max_active_turns == '0)
        begin
            limit = COUNT_W'(1);
        end
        else if (cfg.max_active_turns > COUNT_W'(ACTIVE_LIMIT_MAX))
        begin
            limit = COUNT_W'(ACTIVE_LIMIT_MAX);
        end
        else
        begin
            limit = cfg.max_active_turns;
        end
    end

    always_comb
    begin
        fill_next          = fill_reg;
        active_next        = active_reg;
        scan_idx_next      = scan_idx_reg;
        q_push             = 1'b0;
        q_compact          = 1'b0;
        busy_wr_en         = 1'b0;
        busy_wr_slot       = sid_reg[SLOT_W-1:0];
        busy_wr_val        = 1'b0;
        rd_en              = 1'b0;
        rd_addr            = session_id[SLOT_W-1:0];
        stat.quick         = 1'b1;
        stat.scan_done     = 1'b0;
        stat.clearing      = clearing_reg;
        res_live           = '0;
        res_live.status    = ST_OK;

        if (cmd.capture)
        begin
            // A pump looks up the session of the head job; the others look
            // up their own session.
            rd_en         = 1'b1;
            scan_idx_next = '0;
            if (op_in == CMD_PUMP)
            begin
                rd_addr = q_sess_reg[0][SLOT_W-1:0];
            end
        end
        else if (cmd.scan_step)
        begin
            if (!busy_rd_reg)
            begin
                q_compact           = 1'b1;
                fill_next           = fill_reg - COUNT_W'(1);
                active_next         = active_reg + COUNT_W'(1);
                busy_wr_en          = 1'b1;
                busy_wr_slot        = scan_sess[SLOT_W-1:0];
                busy_wr_val         = 1'b1;
                res_live.dispatched = 1'b1;
                res_live.session    = scan_sess;
                res_live.delivery   = scan_dlv;
                stat.scan_done      = 1'b1;
            end
            else if (scan_last)
            begin
                res_live.status = ST_NONE;
                stat.scan_done  = 1'b1;
            end
            else
            begin
                // Fetch the busy bit of the next entry while moving to it.
                scan_idx_next = step_idx;
                rd_en         = 1'b1;
                rd_addr       = q_sess_reg[step_idx][SLOT_W-1:0];
            end
        end
        else if (cmd.exec)
        begin
            case (op_reg)
                CMD_SUBMIT:
                begin
                    if (!cfg.engine_ready)
                    begin
                        res_live.status = ST_NO_EXEC;
                    end
                    else if (fill_reg >= COUNT_W'(QUEUE_DEPTH))
                    begin
                        res_live.status = ST_FULL;
                    end
                    else
                    begin
                        q_push    = 1'b1;
                        fill_next = fill_reg + COUNT_W'(1);
                    end
                end
                CMD_TRY_BEGIN:
                begin
                    if (busy_rd_reg)
                    begin
                        res_live.status = ST_BUSY;
                    end
                    else if (active_reg >= limit)
                    begin
                        res_live.status = ST_CAPACITY;
                    end
                    else
                    begin
                        busy_wr_en  = 1'b1;
                        busy_wr_val = 1'b1;
                        active_next = active_reg + COUNT_W'(1);
                    end
                end
                CMD_END_TURN:
                begin
                    if (!busy_rd_reg)
                    begin
                        res_live.status = ST_END_IGNORED;
                    end
                    else
                    begin
                        busy_wr_en = 1'b1;
                        if (active_reg != '0)
                        begin
                            active_next = active_reg - COUNT_W'(1);
                        end
                    end
                end
                default:
                begin
                    if (!cfg.engine_ready)
                    begin
                        res_live.status = ST_NO_EXEC;
                    end
                    else if ((active_reg >= limit) || (fill_reg == '0))
                    begin
                        res_live.status = ST_NONE;
                    end
                    else
                    begin
                        stat.quick = 1'b0;
                    end
                end
            endcase
        end

        res_live.pending = fill_next;
        res_live.active  = active_next;
    end

    // Job store: append at the fill point, close the gap after a dispatch.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= op_in;
            sid_reg <= session_id;
            dlv_reg <= delivery_id;
        end
        if (q_push)
        begin
            q_sess_reg[fill_reg[QIDX_W-1:0]] <= sid_reg;
            q_dlv_reg[fill_reg[QIDX_W-1:0]]  <= dlv_reg;
        end
        else if (q_compact)
        begin
            for (int k = 0; k < QUEUE_DEPTH - 1; k++)
            begin
                if (QIDX_W'(k) >= scan_idx_reg)
                begin
                    q_sess_reg[k] <= q_sess_reg[k+1];
                    q_dlv_reg[k]  <= q_dlv_reg[k+1];
                end
            end
        end
    end

    // Session table: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            busy_mem[mem_wr_slot] <= mem_wr_val;
        end
        if (rd_en)
        begin
            busy_rd_reg <= busy_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_idx_reg  <= '0;
            fill_reg     <= '0;
            active_reg   <= '0;
            scan_idx_reg <= '0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_idx_reg <= clr_idx_reg + SLOT_W'(1);
                if (clr_idx_reg == SLOT_W'(SESSION_COUNT - 1))
                begin
                    clearing_reg <= 1'b0;
                end
            end
            fill_reg     <= fill_next;
            active_reg   <= active_next;
            scan_idx_reg <= scan_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.save_res)
        begin
            hold_res_reg <= res_live;
        end
        if (cmd.load_live)
        begin
            out_res_reg <= res_live;
        end
        else if (cmd.load_saved)
        begin
            out_res_reg <= hold_res_reg;
        end
    end

    assign out_res = out_res_reg;

endmodule

// ===== hdl/kfd_ctrl.sv =====
module kfd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  kfd_pkg::dp_stat_t stat,
    output kfd_pkg::dp_cmd_t  cmd
);
    import kfd_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        accept;
    logic        out_free;
    logic        finish;

    assign accept   = (state_reg == CS_IDLE) && !stat.clearing && in_valid;
    assign out_free = !out_valid_reg || !out_stall;
    assign finish   = ((state_reg == CS_EXEC) && stat.quick) ||
                      ((state_reg == CS_SCAN) && stat.scan_done);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CS_IDLE:
            begin
                if (accept)
                begin
                    state_next = CS_EXEC;
                end
            end
            CS_EXEC:
            begin
                if (!stat.quick)
                begin
                    state_next = CS_SCAN;
                end
                else
                begin
                    state_next = out_free ? CS_IDLE : CS_HOLD;
                end
            end
            CS_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = out_free ? CS_IDLE : CS_HOLD;
                end
            end
            CS_HOLD:
            begin
                if (out_free)
                begin
                    state_next = CS_IDLE;
                end
            end
            default: state_next = CS_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall       = (state_reg != CS_IDLE) || stat.clearing;
        cmd.capture    = accept;
        cmd.exec       = (state_reg == CS_EXEC);
        cmd.scan_step  = (state_reg == CS_SCAN);
        cmd.load_live  = finish && out_free;
        cmd.save_res   = finish && !out_free;
        cmd.load_saved = (state_reg == CS_HOLD) && out_free;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_live || cmd.load_saved)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CS_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    // A result is parked only while the output register is occupied.
    a_hold_has_output: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == CS_HOLD) |-> out_valid_reg)
        else $error("hold state without a pending output item");

    // The output register is never overwritten while its item is stalled.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_live || cmd.load_saved) |-> !(out_valid_reg && out_stall))
        else $error("output item overwritten while stalled");

    // The scan stays in progress until the datapath reports its end.
    a_scan_continues: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == CS_SCAN) && !stat.scan_done) |=> (state_reg == CS_SCAN))
        else $error("scan left before completion");

    // A result is either delivered now or parked, never both.
    a_one_destination: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.save_res && (cmd.load_live || cmd.load_saved)))
        else $error("result both parked and loaded");
`endif

endmodule

// ===== hdl/keyed_single_flight_dispatcher_core.sv =====
// Keyed single-flight dispatcher. The block keeps a 16-entry queue of pending
// jobs (session number plus delivery tag), one busy bit per session and a
// count of active jobs, and answers every accepted item with exactly one
// result item. The session busy bits live in a 256-entry table with a
// registered read: the cycle in which an item is accepted looks up the busy
// bit of its session, and the next cycle acts on it. The input stalls until
// an item is through, so submit, try-begin and end-turn do not overlap with
// the next item. Pump makes its decision in the same way and then scans the
// queue, checking one queue entry against its session busy bit per cycle
// while already fetching the busy bit of the next entry, until it finds an
// idle session or reaches the end of the queue; it closes the gap in the
// queue when it dispatches. A pump that is refused outright (no executor, at
// the active limit, or an empty queue) answers without a scan. After reset
// the session table is cleared one entry per cycle, and the input stalls
// until the clearing pass is over. Results sit in an output register; when
// it is stalled, a finished result is parked in a hold register and the
// input stalls until the output drains. Configuration is written through a
// small APB port: max_active_turns at address 0 (zero acts as one, values
// above 16 act as 16) and engine_ready at address 4; both read back.
module keyed_single_flight_dispatcher_core (
    input  logic                           clk,
    input  logic                           rst_n,

    // Configuration port.
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [kfd_pkg::ADDR_W-1:0]     paddr,
    input  logic [kfd_pkg::DATA_W-1:0]     pwdata,
    output logic [kfd_pkg::DATA_W-1:0]     prdata,
    output logic                           pready,

    // Command items.
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [kfd_pkg::CMD_W-1:0]      command,
    input  logic [kfd_pkg::SESSION_W-1:0]  session_id,
    input  logic [kfd_pkg::DELIVERY_W-1:0] delivery_id,

    // Result items.
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [kfd_pkg::STATUS_W-1:0]   status,
    output logic                           dispatched,
    output logic [kfd_pkg::SESSION_W-1:0]  out_session,
    output logic [kfd_pkg::DELIVERY_W-1:0] out_delivery,
    output logic [kfd_pkg::COUNT_W-1:0]    pending_total,
    output logic [kfd_pkg::COUNT_W-1:0]    active_total
);
    import kfd_pkg::*;

    cfg_t     cfg;
    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;
    result_t  out_res;

    // Register file for the limit and the executor flag.
    kfd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Sequencer: accepts items, steps the pump scan, routes results.
    kfd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (dp_stat),
        .cmd       (dp_cmd)
    );

    // Queue, session busy table, counters and result registers.
    kfd_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .command     (command),
        .session_id  (session_id),
        .delivery_id (delivery_id),
        .cmd         (dp_cmd),
        .stat        (dp_stat),
        .out_res     (out_res)
    );

    assign status        = out_res.status;
    assign dispatched    = out_res.dispatched;
    assign out_session   = out_res.session;
    assign out_delivery  = out_res.delivery;
    assign pending_total = out_res.pending;
    assign active_total  = out_res.active;

endmodule
